// File: rtl/dq_pkg.sv
// shared constants, operation and status codes, and the cell control bundle
package dq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int OP_W       = 3;
    localparam int VAL_W      = 32;
    localparam int ST_W       = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_RESIZE     = 3'd4,
        OP_CLEAR      = 3'd5,
        OP_QUERY      = 3'd6
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_TOO_LARGE = 2'd3
    } status_t;

    typedef struct packed {
        logic                  front_ins;
        logic                  front_rem;
        logic                  back_ins;
        logic                  fill;
        logic [CNT_W-1:0]      cnt;
        logic [CNT_W-1:0]      req;
        logic [DATA_WIDTH-1:0] data;
    } cell_ctl_t;

endpackage

// File: rtl/dq_cell.sv
// one storage cell of the deque chain, shifting toward either neighbor
module dq_cell
    import dq_pkg::*;
(
    input  logic                  clk,
    input  cell_ctl_t             ctl,
    input  logic [IDX_W-1:0]      idx,
    input  logic [DATA_WIDTH-1:0] prev_data,
    input  logic [DATA_WIDTH-1:0] next_data,
    output logic [DATA_WIDTH-1:0] data_q,
    output logic [DATA_WIDTH-1:0] data_next
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [CNT_W-1:0]      pos;

    assign pos = CNT_W'(idx);

    always_comb
    begin
        data_next = data_reg;
        if (ctl.front_ins)
        begin
            // cell 0 takes the new word, the rest move one place back
            data_next = (idx == '0) ? ctl.data : prev_data;
        end
        else if (ctl.front_rem)
        begin
            data_next = next_data;
        end
        else if (ctl.back_ins && (pos == ctl.cnt))
        begin
            data_next = ctl.data;
        end
        else if (ctl.fill && (pos >= ctl.cnt) && (pos < ctl.req))
        begin
            data_next = ctl.data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data_q = data_reg;

endmodule

// File: rtl/dq_ctrl.sv
// operation decode, element count and status for the deque chain
module dq_ctrl
    import dq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [OP_W-1:0]  operation,
    input  logic [VAL_W-1:0] value,
    input  logic [CNT_W-1:0] new_size,
    output cell_ctl_t        ctl,
    output logic [CNT_W-1:0] count_next,
    output status_t          status
);

    logic [CNT_W-1:0] count_reg;
    logic             full;
    logic             empty;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    always_comb
    begin
        ctl.front_ins = 1'b0;
        ctl.front_rem = 1'b0;
        ctl.back_ins  = 1'b0;
        ctl.fill      = 1'b0;
        ctl.cnt       = count_reg;
        ctl.req       = new_size;
        ctl.data      = value[DATA_WIDTH-1:0];
        count_next    = count_reg;
        status        = ST_OK;
        if (accept)
        begin
            case (op_t'(operation))
                OP_PUSH_BACK:
                begin
                    if (full)
                        status = ST_OVERFLOW;
                    else
                    begin
                        ctl.back_ins = 1'b1;
                        count_next   = count_reg + 1'b1;
                    end
                end
                OP_PUSH_FRONT:
                begin
                    if (full)
                        status = ST_OVERFLOW;
                    else
                    begin
                        ctl.front_ins = 1'b1;
                        count_next    = count_reg + 1'b1;
                    end
                end
                OP_POP_BACK:
                begin
                    if (empty)
                        status = ST_UNDERFLOW;
                    else
                        count_next = count_reg - 1'b1;
                end
                OP_POP_FRONT:
                begin
                    if (empty)
                        status = ST_UNDERFLOW;
                    else
                    begin
                        ctl.front_rem = 1'b1;
                        count_next    = count_reg - 1'b1;
                    end
                end
                OP_RESIZE:
                begin
                    if (new_size > CNT_W'(DEPTH))
                        status = ST_TOO_LARGE;
                    else
                    begin
                        // growing fills the new back slots, shrinking drops them
                        ctl.fill   = (new_size > count_reg);
                        count_next = new_size;
                    end
                end
                OP_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    // query and the unused code leave the state alone
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

// File: rtl/double_ended_queue.sv
// top level of the double-ended queue: cell chain, control and result register
//
// A double-ended queue of up to DEPTH words (16 by default) held in a chain
// of cells, with the front element always in cell 0. Every request (push
// back, push front, pop back, pop front, resize with fill, clear, query)
// acts on all cells at once, a growing resize included: every cell decides
// on its own whether it takes the fill word, so all new back slots are
// written together. A push front shifts the whole chain one cell back and a
// pop front shifts it one cell forward. The result of a request appears in
// the result register on the cycle after it is accepted, and a new request
// is taken in the same cycle as the previous result is taken, so the block
// sustains one request per cycle while the result side keeps up. A pop on
// an empty queue, a push on a full one and a resize beyond DEPTH change
// nothing and are flagged in status. Clear only resets the count; stored
// words beyond the count are never shown. An empty queue reports zero for
// both the front and the back value.
module double_ended_queue
    import dq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // request channel
    input  logic             req_valid,
    output logic             req_stall,
    input  logic [OP_W-1:0]  operation,
    input  logic [VAL_W-1:0] value,
    input  logic [CNT_W-1:0] new_size,
    // result channel
    output logic             res_valid,
    input  logic             res_stall,
    output logic [VAL_W-1:0] front_value,
    output logic [VAL_W-1:0] back_value,
    output logic [CNT_W-1:0] count,
    output logic             is_empty,
    output logic [ST_W-1:0]  status
);

    logic                  accept;
    cell_ctl_t             ctl;
    logic [CNT_W-1:0]      count_next;
    status_t               st_next;

    logic [DATA_WIDTH-1:0] cell_q    [DEPTH];
    logic [DATA_WIDTH-1:0] cell_next [DEPTH];

    logic [IDX_W-1:0]      back_idx;
    logic [DATA_WIDTH-1:0] front_next;
    logic [DATA_WIDTH-1:0] back_next;

    logic                  res_valid_reg;
    logic                  res_valid_next;
    logic [DATA_WIDTH-1:0] front_reg;
    logic [DATA_WIDTH-1:0] back_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  empty_reg;
    status_t               status_reg;

    // a request waits only while a result is held and not being taken
    assign req_stall = res_valid_reg && res_stall;
    assign accept    = req_valid && !req_stall;

    dq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .operation  (operation),
        .value      (value),
        .new_size   (new_size),
        .ctl        (ctl),
        .count_next (count_next),
        .status     (st_next)
    );

    // the chain: each cell sees its neighbors toward the front and the back
    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] prev_data;
            logic [DATA_WIDTH-1:0] next_data;

            if (i == 0)
            begin : g_first
                assign prev_data = cell_q[i];
            end
            else
            begin : g_mid_prev
                assign prev_data = cell_q[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign next_data = cell_q[i];
            end
            else
            begin : g_mid_next
                assign next_data = cell_q[i+1];
            end

            dq_cell u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .idx       (IDX_W'(i)),
                .prev_data (prev_data),
                .next_data (next_data),
                .data_q    (cell_q[i]),
                .data_next (cell_next[i])
            );
        end
    endgenerate

    // front and back after the operation, zero when the queue ends up empty
    assign back_idx   = IDX_W'(count_next - 1'b1);
    assign front_next = (count_next == '0) ? '0 : cell_next[0];
    assign back_next  = (count_next == '0) ? '0 : cell_next[back_idx];

    always_comb
    begin
        res_valid_next = res_valid_reg && res_stall;
        if (accept)
            res_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    // result payload is loaded only with an accepted request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            front_reg  <= front_next;
            back_reg   <= back_next;
            count_reg  <= count_next;
            empty_reg  <= (count_next == '0);
            status_reg <= st_next;
        end
    end

    assign res_valid   = res_valid_reg;
    assign front_value = VAL_W'(front_reg);
    assign back_value  = VAL_W'(back_reg);
    assign count       = count_reg;
    assign is_empty    = empty_reg;
    assign status      = status_reg;

endmodule

// File: rtl/dq_checker.sv
// port-level checks for the double-ended queue and their binding
module dq_checker
    import dq_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             res_valid,
    input logic             res_stall,
    input logic [VAL_W-1:0] front_value,
    input logic [VAL_W-1:0] back_value,
    input logic [CNT_W-1:0] count,
    input logic             is_empty,
    input logic [ST_W-1:0]  status
);

    // a stalled result stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (is_empty == (count == '0)))
        else $error("empty flag disagrees with count");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && is_empty |-> (front_value == '0) && (back_value == '0))
        else $error("empty queue shows nonzero values");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (count <= CNT_W'(DEPTH)))
        else $error("count beyond depth");

    a_flag_state: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && ((status == ST_OVERFLOW && count != CNT_W'(DEPTH))
                      || (status == ST_UNDERFLOW && count != '0)) |-> 1'b0)
        else $error("overflow or underflow flagged with wrong count");

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);
